// File: sv/oohr_pkg.sv
// ----------------------------------------------------------------------------
// oohr_pkg
// Shared types and constants for the overwrite-oldest history ring.
// ----------------------------------------------------------------------------
package oohr_pkg;

    // Default sizing of the ring
    localparam int DEPTH_DEF       = 64;
    localparam int RECORD_BITS_DEF = 64;

    // Upper bound on DEPTH; sizes the address field of a queued operation
    localparam int DEPTH_MAX  = 64;
    localparam int ADDR_W_MAX = $clog2(DEPTH_MAX);

    // Fixed port widths
    localparam int CMD_W   = 2;
    localparam int REC_W   = 64;
    localparam int POS_W   = 7;

    // Command queue between front and back (power of two)
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_HISTORY = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,  // store record, acknowledge
        OP_EMPTY = 2'd1,  // single result with nothing read
        OP_READ  = 2'd2,  // single read of one slot
        OP_BURST = 2'd3   // run of reads, newest first
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [ADDR_W_MAX-1:0] addr;   // slot written/read, or first of burst
        logic [POS_W-1:0]      len;    // burst length
        logic [POS_W-1:0]      count;  // entries held after the command
        logic                  full;
    } op_t;

endpackage

// File: sv/oohr_front.sv
// ----------------------------------------------------------------------------
// oohr_front
// Accepts commands, keeps the ring pointers and count, and turns each item
// into one queued operation with its slot address already resolved.
// ----------------------------------------------------------------------------
module oohr_front #(
    parameter int DEPTH       = oohr_pkg::DEPTH_DEF,
    parameter int RECORD_BITS = oohr_pkg::RECORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [oohr_pkg::CMD_W-1:0]   cmd,
    input  logic [oohr_pkg::REC_W-1:0]   record,
    input  logic [oohr_pkg::POS_W-1:0]   position,
    output logic                         q_push,
    input  logic                         q_full,
    output oohr_pkg::op_t                q_op,
    output logic [RECORD_BITS-1:0]       q_rec
);
    import oohr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [POS_W:0]   DEPTH_SUM = (POS_W + 1)'(DEPTH);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] old_reg, old_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full_reg, full_next;

    logic             accept;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] old_inc;
    logic [PTR_W-1:0] wp_dec;
    logic [POS_W-1:0] count_pos;
    logic [POS_W:0]   rd_sum;
    logic [POS_W:0]   rd_wrap;
    logic [POS_W-1:0] hist_n;
    logic [CNT_W-1:0] count_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign q_rec    = record[RECORD_BITS-1:0];

    // Pointer arithmetic with wrap at DEPTH
    assign wp_inc    = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign old_inc   = (old_reg == LAST_SLOT) ? '0 : old_reg + 1'b1;
    assign wp_dec    = (wp_reg == '0) ? LAST_SLOT : wp_reg - 1'b1;
    assign count_pos = POS_W'(count_reg);
    assign count_inc = count_reg + 1'b1;

    // Offset from oldest: sum stays below twice DEPTH when in range
    assign rd_sum  = (POS_W + 1)'(old_reg) + (POS_W + 1)'(position);
    assign rd_wrap = (rd_sum >= DEPTH_SUM) ? rd_sum - DEPTH_SUM : rd_sum;

    // History length saturates at the stored count
    assign hist_n = (position < count_pos) ? position : count_pos;

    // Command decode and next state
    always_comb
    begin
        wp_next    = wp_reg;
        old_next   = old_reg;
        count_next = count_reg;
        full_next  = full_reg;
        q_op.kind  = OP_EMPTY;
        q_op.addr  = '0;
        q_op.len   = '0;
        unique case (cmd_t'(cmd))
            CMD_PUSH:
            begin
                q_op.kind = OP_WRITE;
                q_op.addr = ADDR_W_MAX'(wp_reg);
                wp_next   = wp_inc;
                if (full_reg)
                begin
                    old_next = old_inc;
                end
                else
                begin
                    count_next = count_inc;
                    full_next  = (count_inc == FULL_CNT);
                end
            end
            CMD_READ:
            begin
                if (position < count_pos)
                begin
                    q_op.kind = OP_READ;
                    q_op.addr = ADDR_W_MAX'(rd_wrap[PTR_W-1:0]);
                end
            end
            CMD_HISTORY:
            begin
                if (hist_n != '0)
                begin
                    q_op.kind = OP_BURST;
                    q_op.addr = ADDR_W_MAX'(wp_dec);
                    q_op.len  = hist_n;
                end
            end
            CMD_CLEAR:
            begin
                wp_next    = '0;
                old_next   = '0;
                count_next = '0;
                full_next  = 1'b0;
            end
            default:
            begin
                q_op.kind = OP_EMPTY;
            end
        endcase
        q_op.count = POS_W'(count_next);
        q_op.full  = full_next;
    end

    // Ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            old_reg   <= '0;
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg    <= wp_next;
            old_reg   <= old_next;
            count_reg <= count_next;
            full_reg  <= full_next;
        end
    end

    // Full flag tracks the count exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> count_reg == FULL_CNT)
        else $error("full flag set without a full count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> count_reg < FULL_CNT)
        else $error("count reached depth without full flag");

    // Clear returns every pointer to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_CLEAR |=> count_reg == '0 && wp_reg == '0 && old_reg == '0)
        else $error("clear left ring state behind");

endmodule

// File: sv/oohr_queue.sv
// ----------------------------------------------------------------------------
// oohr_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module oohr_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] head
);
    import oohr_pkg::*;

    logic [W-1:0]      store_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full      = (fill_reg == (QPTR_W + 1)'(QDEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// File: sv/oohr_back.sv
// ----------------------------------------------------------------------------
// oohr_back
// Executes queued operations against the slot memory: writes records,
// single reads and newest-first bursts, and drives the result register.
// ----------------------------------------------------------------------------
module oohr_back #(
    parameter int DEPTH       = oohr_pkg::DEPTH_DEF,
    parameter int RECORD_BITS = oohr_pkg::RECORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  oohr_pkg::op_t               q_op,
    input  logic [RECORD_BITS-1:0]      q_rec,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [oohr_pkg::REC_W-1:0]  record_out,
    output logic [oohr_pkg::POS_W-1:0]  stored_count,
    output logic                        is_full,
    output logic                        last
);
    import oohr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    // Slot memory
    logic [RECORD_BITS-1:0] mem [DEPTH];
    logic [RECORD_BITS-1:0] rd_data_reg;

    // Burst sequencer
    logic             busy_reg;
    logic [PTR_W-1:0] bur_addr_reg;
    logic [POS_W-1:0] bur_left_reg;
    logic [POS_W-1:0] bur_count_reg;
    logic             bur_full_reg;

    // Read stage
    logic             s1_valid_reg;
    logic             s1_hit_reg;
    logic             s1_last_reg;
    logic [POS_W-1:0] s1_count_reg;
    logic             s1_full_reg;

    // Result register
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [RECORD_BITS-1:0] out_rec_reg;
    logic [POS_W-1:0]       out_count_reg;
    logic                   out_full_reg;
    logic                   out_last_reg;

    logic             s1_adv;
    logic             issue;
    logic [PTR_W-1:0] src_addr;
    logic [PTR_W-1:0] src_dec;
    logic             src_read;
    logic             src_write;
    logic             src_last;
    logic [POS_W-1:0] src_count;
    logic             src_full;
    logic             start_burst;

    // Stage handshakes
    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue  = (!s1_valid_reg || s1_adv) && (busy_reg || q_valid);
    assign q_pop  = issue && !busy_reg;

    // Select the burst sequencer or the queue head
    always_comb
    begin
        if (busy_reg)
        begin
            src_addr  = bur_addr_reg;
            src_read  = 1'b1;
            src_write = 1'b0;
            src_last  = (bur_left_reg == POS_W'(1));
            src_count = bur_count_reg;
            src_full  = bur_full_reg;
        end
        else
        begin
            src_addr  = q_op.addr[PTR_W-1:0];
            src_read  = (q_op.kind == OP_READ) || (q_op.kind == OP_BURST);
            src_write = (q_op.kind == OP_WRITE);
            src_last  = (q_op.kind != OP_BURST) || (q_op.len == POS_W'(1));
            src_count = q_op.count;
            src_full  = q_op.full;
        end
    end

    assign src_dec     = (src_addr == '0) ? LAST_SLOT : src_addr - 1'b1;
    assign start_burst = q_pop && (q_op.kind == OP_BURST) && (q_op.len != POS_W'(1));

    // Memory port: one write or one registered read per issue
    always_ff @(posedge clk)
    begin
        if (issue && src_write)
        begin
            mem[src_addr] <= q_rec;
        end
        if (issue && src_read)
        begin
            rd_data_reg <= mem[src_addr];
        end
    end

    // Burst sequencer: walks from newest towards oldest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            bur_addr_reg <= '0;
            bur_left_reg <= '0;
        end
        else if (issue)
        begin
            if (busy_reg)
            begin
                busy_reg     <= (bur_left_reg != POS_W'(1));
                bur_addr_reg <= src_dec;
                bur_left_reg <= bur_left_reg - 1'b1;
            end
            else if (start_burst)
            begin
                busy_reg     <= 1'b1;
                bur_addr_reg <= src_dec;
                bur_left_reg <= q_op.len - 1'b1;
            end
        end
    end

    // Burst status is constant over the run
    always_ff @(posedge clk)
    begin
        if (start_burst)
        begin
            bur_count_reg <= q_op.count;
            bur_full_reg  <= q_op.full;
        end
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_hit_reg   <= src_read;
            s1_last_reg  <= src_last;
            s1_count_reg <= src_count;
            s1_full_reg  <= src_full;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_hit_reg   <= s1_hit_reg;
            out_rec_reg   <= s1_hit_reg ? rd_data_reg : '0;
            out_count_reg <= s1_count_reg;
            out_full_reg  <= s1_full_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = out_hit_reg;
    assign record_out   = REC_W'(out_rec_reg);
    assign stored_count = out_count_reg;
    assign is_full      = out_full_reg;
    assign last         = out_last_reg;

    // A running burst always has entries left
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> bur_left_reg != '0)
        else $error("burst sequencer busy with nothing left");

    // Results without a stored entry carry a zero record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_rec_reg == '0)
        else $error("non-read result carries record data");

    // The queue is only drained between bursts
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !busy_reg)
        else $error("queue popped while empty or mid-burst");

endmodule

// File: sv/overwrite_oldest_history_ring_core.sv
// ----------------------------------------------------------------------------
// overwrite_oldest_history_ring_core
// History ring of records that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command item: cmd, record,
//   position. Push stores a record, read returns the entry at an offset
//   from the oldest, history returns up to position newest entries newest
//   first, clear empties the ring. Output channel (out_valid/out_ready)
//   delivers result items; last marks the final result of a command.
//   The first result comes from the result register, after the operation
//   queue and the read stage. Throughput: one command per cycle for push,
//   read and clear while results are taken; a history burst holds the queue
//   while the burst sequencer steps the single memory read port, one read per result.
//   A four-entry command queue sits between the command front and the
//   memory back, so commands keep being accepted while results stall;
//   in_ready drops only once that queue is full. A stalled receiver holds
//   the result register and the read stage behind it.
//   Reset empties the ring, the queue and the pipeline; slot contents are
//   not cleared, and no slot is read before it has been written.
// ----------------------------------------------------------------------------
module overwrite_oldest_history_ring_core #(
    parameter int DEPTH       = oohr_pkg::DEPTH_DEF,
    parameter int RECORD_BITS = oohr_pkg::RECORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [oohr_pkg::CMD_W-1:0]  cmd,
    input  logic [oohr_pkg::REC_W-1:0]  record,
    input  logic [oohr_pkg::POS_W-1:0]  position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [oohr_pkg::REC_W-1:0]  record_out,
    output logic [oohr_pkg::POS_W-1:0]  stored_count,
    output logic                        is_full,
    output logic                        last
);
    import oohr_pkg::*;

    localparam int QW = $bits(op_t) + RECORD_BITS;

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    op_t                    f_op;
    logic [RECORD_BITS-1:0] f_rec;
    op_t                    b_op;
    logic [RECORD_BITS-1:0] b_rec;
    logic [QW-1:0]          q_in;
    logic [QW-1:0]          q_head;

    assign q_in          = {f_op, f_rec};
    assign {b_op, b_rec} = q_head;

    // Command front
    oohr_front #(
        .DEPTH       (DEPTH),
        .RECORD_BITS (RECORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .record   (record),
        .position (position),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_op     (f_op),
        .q_rec    (f_rec)
    );

    // Operation queue
    oohr_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Memory back end
    oohr_back #(
        .DEPTH       (DEPTH),
        .RECORD_BITS (RECORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_op         (b_op),
        .q_rec        (b_rec),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .record_out   (record_out),
        .stored_count (stored_count),
        .is_full      (is_full),
        .last         (last)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwrite-oldest history ring core.
// A short table of commands runs first, then random traffic that fills the
// ring and overwrites it. A ring model predicts the results not given in the table.
// Commands change on the falling edge and results are checked on the rising
// edge against the oldest prediction. Both sides idle at random, and there is
// one long receiver hold-off that backs the ring up into its input.
// ----------------------------------------------------------------------------
module tb;

    import oohr_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int NUM_DIR     = 19;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 20;

    // One result item as the block presents it
    typedef struct packed {
        logic             valid;
        logic [REC_W-1:0] rec;
        logic [POS_W-1:0] count;
        logic             full;
        logic             last;
    } ring_result_t;

    // One row of the directed table
    typedef struct {
        cmd_t             op;
        logic [REC_W-1:0] rec;
        logic [POS_W-1:0] pos;
        bit               typed;
        ring_result_t     want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [CMD_W-1:0] cmd;
    logic [REC_W-1:0] record;
    logic [POS_W-1:0] position;
    logic             out_valid;
    logic             out_ready;
    logic             valid_res;
    logic [REC_W-1:0] record_out;
    logic [POS_W-1:0] stored_count;
    logic             is_full;
    logic             last;

    // Ring model state
    logic [REC_W-1:0] ring_slots [RING_DEPTH];
    int               wr_idx;
    int               old_idx;
    int               held;
    bit               held_full;

    ring_result_t     expected_results [$];
    stim_row_t        dir_rows [NUM_DIR];
    int               fail_count;
    int               burst_left;
    bit               hold_req;
    int               idle_cycles;
    int               rx_tick;

    overwrite_oldest_history_ring_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .record       (record),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .record_out   (record_out),
        .stored_count (stored_count),
        .is_full      (is_full),
        .last         (last)
    );

    always #1 clk = ~clk;

    // Single result with nothing read: acks, misses and empty histories
    function automatic ring_result_t lone_result(input logic [POS_W-1:0] n, input logic f);
        return {1'b0, {REC_W{1'b0}}, n, f, 1'b1};
    endfunction

    // Queue a result item carrying the current count and full status
    task automatic log_result(input bit keep, input logic v, input logic [REC_W-1:0] r,
                              input logic l);
        ring_result_t res;
        begin
            res.valid = v;
            res.rec   = v ? r : '0;
            res.count = held[POS_W-1:0];
            res.full  = held_full;
            res.last  = l;
            if (keep)
                expected_results.push_back(res);
        end
    endtask

    // Ring model: apply one accepted command and predict its result items
    task automatic ring_model_step(input cmd_t op, input logic [REC_W-1:0] rec,
                                   input logic [POS_W-1:0] pos, input bit keep);
        int take;
        int i;
        begin
            case (op)
                CMD_PUSH:
                begin
                    ring_slots[wr_idx] = rec;
                    wr_idx = (wr_idx + 1) % RING_DEPTH;
                    if (held_full)
                        old_idx = (old_idx + 1) % RING_DEPTH;
                    else
                    begin
                        held++;
                        if (held >= RING_DEPTH)
                        begin
                            held      = RING_DEPTH;
                            held_full = 1'b1;
                        end
                    end
                    log_result(keep, 1'b0, '0, 1'b1);
                end
                CMD_READ:
                begin
                    if (int'(pos) >= held)
                        log_result(keep, 1'b0, '0, 1'b1);
                    else
                        log_result(keep, 1'b1,
                                   ring_slots[(old_idx + int'(pos)) % RING_DEPTH], 1'b1);
                end
                CMD_HISTORY:
                begin
                    take = (int'(pos) < held) ? int'(pos) : held;
                    if (take == 0)
                        log_result(keep, 1'b0, '0, 1'b1);
                    for (i = 0; i < take; i++)
                        log_result(keep, 1'b1,
                                   ring_slots[(wr_idx + RING_DEPTH - 1 - i) % RING_DEPTH],
                                   i + 1 == take);
                end
                default:
                begin
                    for (i = 0; i < RING_DEPTH; i++)
                        ring_slots[i] = '0;
                    wr_idx    = 0;
                    old_idx   = 0;
                    held      = 0;
                    held_full = 1'b0;
                    log_result(keep, 1'b0, '0, 1'b1);
                end
            endcase
        end
    endtask

    // Offer one item from a falling edge; returns at the falling edge after it is taken
    task automatic offer_item(input cmd_t op, input logic [REC_W-1:0] rec,
                              input logic [POS_W-1:0] pos, input bit typed,
                              input ring_result_t want);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            cmd      <= op;
            record   <= rec;
            position <= pos;
            in_valid <= 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
            ring_model_step(op, rec, pos, !typed);
            if (typed)
                expected_results.push_back(want);
            @(negedge clk);
        end
    endtask

    // Random item with the given weights in percent; clear takes what is left
    task automatic offer_random(input int w_push, input int w_read, input int w_hist);
        int               roll;
        cmd_t             op;
        logic [REC_W-1:0] rec;
        logic [POS_W-1:0] pos;
        begin
            roll = $urandom_range(0, 99);
            if (roll < w_push)
                op = CMD_PUSH;
            else if (roll < w_push + w_read)
                op = CMD_READ;
            else if (roll < w_push + w_read + w_hist)
                op = CMD_HISTORY;
            else
                op = CMD_CLEAR;
            case ($urandom_range(0, 9))
                0:       rec = '0;
                1:       rec = '1;
                default: rec = {$urandom, $urandom};
            endcase
            roll = $urandom_range(0, 9);
            if (op == CMD_HISTORY)
                pos = (roll < 5) ? POS_W'($urandom_range(0, 8)) :
                      (roll < 8) ? POS_W'($urandom_range(0, held)) :
                                   POS_W'($urandom_range(0, RING_DEPTH));
            else
                pos = (roll < 7) ? POS_W'($urandom_range(0, held)) :
                                   POS_W'($urandom_range(0, RING_DEPTH));
            offer_item(op, rec, pos, 1'b0, '0);
        end
    endtask

    // Hold the sender until every predicted result has arrived
    task automatic drain_results;
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            do
                @(negedge clk);
            while (expected_results.size() != 0);
        end
    endtask

    task automatic check_field(input string name, input logic [REC_W-1:0] want,
                               input logic [REC_W-1:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                fail_count++;
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        ring_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: valid_res %b record_out %h count %0d",
                         $time, valid_res, record_out, stored_count);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("valid_res",    REC_W'(want.valid), REC_W'(valid_res));
                check_field("record_out",   want.rec,           record_out);
                check_field("stored_count", REC_W'(want.count), REC_W'(stored_count));
                check_field("is_full",      REC_W'(want.full),  REC_W'(is_full));
                check_field("last",         REC_W'(want.last),  REC_W'(last));
            end
        end
    end

    // Watchdog on stretches with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("overwrite_oldest_history_ring_core: mismatch");
            $finish;
        end
    end

    // Receiver: cycles through ready patterns, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        rx_tick   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            rx_tick++;
            case ((rx_tick / 50) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= rx_tick[0];
            endcase
        end
    end

    // Stimulus
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_PUSH;
        record      = '0;
        position    = '0;
        fail_count  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        wr_idx      = 0;
        old_idx     = 0;
        held        = 0;
        held_full   = 1'b0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_slots[i] = '0;

        // Empty ring, basic pushes, reads in and out of range, histories, clear
        dir_rows[0]  = '{CMD_READ,    '0, 7'd0,  1'b1, lone_result(7'd0, 1'b0)};
        dir_rows[1]  = '{CMD_HISTORY, '0, 7'd64, 1'b1, lone_result(7'd0, 1'b0)};
        dir_rows[2]  = '{CMD_HISTORY, '1, 7'd0,  1'b1, lone_result(7'd0, 1'b0)};
        dir_rows[3]  = '{CMD_PUSH,    '1, 7'd0,  1'b1, lone_result(7'd1, 1'b0)};
        dir_rows[4]  = '{CMD_PUSH,    '0, 7'd64, 1'b1, lone_result(7'd2, 1'b0)};
        dir_rows[5]  = '{CMD_PUSH,    64'h5A5A_C3C3_0F0F_9669, 7'd1, 1'b1,
                         lone_result(7'd3, 1'b0)};
        dir_rows[6]  = '{CMD_PUSH,    64'h8000_0000_0000_0001, 7'd0, 1'b1,
                         lone_result(7'd4, 1'b0)};
        dir_rows[7]  = '{CMD_READ,    '0, 7'd0,  1'b0, '0};
        dir_rows[8]  = '{CMD_READ,    '0, 7'd3,  1'b0, '0};
        dir_rows[9]  = '{CMD_READ,    '0, 7'd4,  1'b1, lone_result(7'd4, 1'b0)};
        dir_rows[10] = '{CMD_READ,    '1, 7'd64, 1'b1, lone_result(7'd4, 1'b0)};
        dir_rows[11] = '{CMD_HISTORY, '0, 7'd0,  1'b1, lone_result(7'd4, 1'b0)};
        dir_rows[12] = '{CMD_HISTORY, '0, 7'd1,  1'b0, '0};
        dir_rows[13] = '{CMD_HISTORY, '0, 7'd3,  1'b0, '0};
        dir_rows[14] = '{CMD_HISTORY, '0, 7'd64, 1'b0, '0};
        dir_rows[15] = '{CMD_CLEAR,   '1, 7'd63, 1'b1, lone_result(7'd0, 1'b0)};
        dir_rows[16] = '{CMD_READ,    '0, 7'd0,  1'b1, lone_result(7'd0, 1'b0)};
        dir_rows[17] = '{CMD_PUSH,    64'h0123_4567_89AB_CDEF, 7'd0, 1'b1,
                         lone_result(7'd1, 1'b0)};
        dir_rows[18] = '{CMD_HISTORY, '0, 7'd2,  1'b0, '0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        for (int r = 0; r < NUM_DIR; r++)
            offer_item(dir_rows[r].op, dir_rows[r].rec, dir_rows[r].pos,
                       dir_rows[r].typed, dir_rows[r].want);

        // Mixed traffic with the odd clear
        for (int n = 0; n < 20; n++)
            offer_random(45, 20, 25);
        drain_results();

        // Fill to full and overwrite, starting under a long receiver hold-off
        hold_req = 1'b1;
        while (!held_full)
            offer_random(90, 5, 5);
        repeat (12) offer_random(70, 15, 15);

        // Full-depth reads and histories, then mixed traffic again
        offer_item(CMD_HISTORY, '0, 7'd64, 1'b0, '0);
        offer_item(CMD_READ,    '0, 7'd63, 1'b0, '0);
        offer_item(CMD_READ,    '0, 7'd64, 1'b0, '0);
        for (int n = 0; n < 15; n++)
            offer_random(30, 30, 30);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("overwrite_oldest_history_ring_core: match");
        else
            $display("overwrite_oldest_history_ring_core: mismatch");
        $finish;
    end

endmodule

// File: overwrite_oldest_history_ring_core.f
sv/oohr_pkg.sv
sv/oohr_front.sv
sv/oohr_queue.sv
sv/oohr_back.sv
sv/overwrite_oldest_history_ring_core.sv
sim/tb.sv
